FILE: rtl/core/smia_pkg.sv
`timescale 1ns / 1ps
package smia_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_REM = 3'd5,
		OP_POW = 3'd6
	} op_t;

	localparam logic [1:0] K_POS = 2'd0;
	localparam logic [1:0] K_NEG = 2'd1;
	localparam logic [1:0] K_BASED = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_OVF = 3'd1;
	localparam logic [2:0] ST_INEXACT = 3'd2;
	localparam logic [2:0] ST_DIVZERO = 3'd3;
	localparam logic [2:0] ST_ZPZ = 3'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [63:0] x_mag;
		logic [1:0] x_kind;
		logic [63:0] y_mag;
		logic [1:0] y_kind;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_mag;
		logic [1:0] result_kind;
		logic [2:0] status;
	} out_word_t;

	// Control for the shared shift-add multiplier.
	typedef struct packed {
		logic start;
		logic wrap;
	} mul_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mul_sts_t;

endpackage

FILE: rtl/core/sign_magnitude_integer_alu.sv
`timescale 1ns / 1ps
// Sequence: add and sub go from decode straight to the result register; div, mod and rem
// run on the serial divider, mul on the serial multiplier; pow runs up to 2 * WORD_BITS
// serial multiplies on the shared shift-add multiplier.
// Throughput: one word at a time; a new word is accepted once the result is taken.
// Reset: arst_n clears the sequencer and the output valid; no result is pending.
module sign_magnitude_integer_alu import smia_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_MUL,
		S_POW_STEP,
		S_POW_WAIT,
		S_DONE
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [1:0]           xt_q;
	logic [1:0]           yt_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] ex_q;
	logic [WORD_BITS-1:0] r_q;
	logic                 sq_q;
	logic [WORD_BITS-1:0] mag_q;
	logic [1:0]           kind_q;
	logic [2:0]           st_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	mul_ctl_t             mctl;
	mul_sts_t             msts;
	logic [WORD_BITS-1:0] ma;
	logic [WORD_BITS-1:0] mb;
	logic [WORD_BITS-1:0] mp;
	logic                 dstart;
	logic                 ddone;
	logic [WORD_BITS-1:0] dq;
	logic [WORD_BITS-1:0] dr;

	logic                 based;
	logic                 xneg;
	logic                 yneg;
	logic [WORD_BITS:0]   addsum;
	logic [WORD_BITS:0]   ymx;
	logic [WORD_BITS:0]   xmy;
	logic [1:0]           xtn;
	logic [1:0]           ytn;

	// Kind 3 reads as based.
	assign xtn = (in_data.x_kind == 2'd3) ? K_BASED : in_data.x_kind;
	assign ytn = (in_data.y_kind == 2'd3) ? K_BASED : in_data.y_kind;

	assign based = (xt_q == K_BASED) || (yt_q == K_BASED);
	assign xneg = (xt_q == K_NEG);
	assign yneg = (yt_q == K_NEG);

	// Adder and subtractor paths shared by add and sub.
	assign addsum = {1'b0, y_q} + {1'b0, x_q};
	assign ymx = {1'b0, y_q} - {1'b0, x_q};
	assign xmy = {1'b0, x_q} - {1'b0, y_q};

	smia_mul #(.WORD_BITS(WORD_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb), .sts(msts), .p(mp)
	);

	smia_div #(.WORD_BITS(WORD_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(y_q), .den(x_q),
		.done(ddone), .quo(dq), .rem(dr)
	);

	// Operand selection and start strobes for the shared multiplier and the divider.
	always_comb begin
		mctl.start = 1'b0;
		mctl.wrap = based;
		ma = x_q;
		mb = y_q;
		dstart = 1'b0;
		if (state_q == S_DECODE) begin
			if (op_q == OP_MUL) begin
				mctl.start = 1'b1;
			end
			if ((op_q == OP_DIV || op_q == OP_MOD || op_q == OP_REM) && x_q != '0) begin
				dstart = 1'b1;
			end
		end
		if (state_q == S_POW_STEP) begin
			mctl.start = 1'b1;
			if (!sq_q) begin
				ma = r_q;
				mb = base_q;
			end else begin
				ma = base_q;
				mb = base_q;
			end
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !out_valid_q) begin
						op_q <= op_t'(in_data.operation);
						x_q <= in_data.x_mag[WORD_BITS-1:0];
						y_q <= in_data.y_mag[WORD_BITS-1:0];
						xt_q <= xtn;
						yt_q <= ytn;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					mag_q <= '0;
					kind_q <= K_POS;
					st_q <= ST_OK;
					state_q <= S_DONE;
					case (op_q)
						OP_ADD: begin
							kind_q <= xt_q;
							if (based) begin
								mag_q <= addsum[WORD_BITS-1:0];
							end else if (xneg == yneg) begin
								if (addsum[WORD_BITS]) begin
									st_q <= ST_OVF;
								end else begin
									mag_q <= addsum[WORD_BITS-1:0];
								end
							end else if (!ymx[WORD_BITS]) begin
								mag_q <= ymx[WORD_BITS-1:0];
								kind_q <= (ymx == '0 || xneg) ? K_POS : K_NEG;
							end else begin
								mag_q <= xmy[WORD_BITS-1:0];
							end
						end
						OP_SUB: begin
							kind_q <= xt_q;
							if (based) begin
								mag_q <= ymx[WORD_BITS-1:0];
							end else if (xneg != yneg) begin
								kind_q <= yt_q;
								if (addsum[WORD_BITS]) begin
									st_q <= ST_OVF;
								end else begin
									mag_q <= addsum[WORD_BITS-1:0];
								end
							end else if (xmy[WORD_BITS]) begin
								mag_q <= ymx[WORD_BITS-1:0];
							end else begin
								mag_q <= xmy[WORD_BITS-1:0];
								kind_q <= (xmy == '0 || xneg) ? K_POS : K_NEG;
							end
						end
						OP_MUL: begin
							state_q <= S_MUL;
						end
						OP_DIV, OP_MOD, OP_REM: begin
							if (x_q == '0) begin
								st_q <= ST_DIVZERO;
							end else begin
								state_q <= S_DIV;
							end
						end
						OP_POW: begin
							if (x_q == '0 && y_q == '0) begin
								st_q <= ST_ZPZ;
							end else begin
								if (yneg) begin
									kind_q <= x_q[0] ? K_NEG : K_POS;
								end else begin
									kind_q <= yt_q;
								end
								// An even exponent skips the first multiply and squares
								// with the exponent already shifted.
								base_q <= y_q;
								ex_q <= x_q[0] ? x_q : (x_q >> 1);
								r_q <= WORD_BITS'(1);
								sq_q <= !x_q[0];
								if (x_q == '0) begin
									mag_q <= WORD_BITS'(1);
								end else begin
									state_q <= S_POW_STEP;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_MUL: begin
					if (msts.done) begin
						state_q <= S_DONE;
						if (msts.ovf) begin
							st_q <= ST_OVF;
						end else begin
							mag_q <= mp;
							kind_q <= based ? xt_q : ((xneg == yneg) ? K_POS : K_NEG);
						end
					end
				end
				S_DIV: begin
					if (ddone) begin
						state_q <= S_DONE;
						case (op_q)
							OP_DIV: begin
								if (based) begin
									mag_q <= dq;
									kind_q <= xt_q;
								end else if (dr != '0) begin
									st_q <= ST_INEXACT;
								end else begin
									mag_q <= dq;
									kind_q <= (xneg == yneg) ? K_POS : K_NEG;
								end
							end
							OP_MOD: begin
								if (based) begin
									mag_q <= dr;
									kind_q <= xt_q;
								end else begin
									mag_q <= xneg ? (y_q - dr) : dr;
									kind_q <= K_POS;
								end
							end
							default: begin
								mag_q <= dr;
								kind_q <= xt_q;
							end
						endcase
					end
				end
				S_POW_STEP: begin
					state_q <= S_POW_WAIT;
				end
				S_POW_WAIT: begin
					if (msts.done) begin
						if (msts.ovf) begin
							st_q <= ST_OVF;
							state_q <= S_DONE;
						end else if (!sq_q) begin
							// Multiply step done; shift exponent, square if bits remain.
							r_q <= mp;
							ex_q <= ex_q >> 1;
							if ((ex_q >> 1) == '0) begin
								mag_q <= mp;
								state_q <= S_DONE;
							end else begin
								sq_q <= 1'b1;
								state_q <= S_POW_STEP;
							end
						end else begin
							// Square done; next bit decides multiply or square again.
							base_q <= mp;
							if (ex_q[0]) begin
								sq_q <= 1'b0;
							end else begin
								ex_q <= ex_q >> 1;
								sq_q <= 1'b1;
							end
							state_q <= S_POW_STEP;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.result_mag <= (st_q == ST_OK) ? 64'(mag_q) : '0;
						out_q.result_kind <= (st_q == ST_OK) ? kind_q : K_POS;
						out_q.status <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: rtl/core/smia_mul.sv
`timescale 1ns / 1ps
module smia_mul import smia_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mul_ctl_t             ctl,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output mul_sts_t             sts,
	output logic [WORD_BITS-1:0] p
);

	localparam int CW = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] mcand_q;
	logic [WORD_BITS-1:0] mplier_q;
	logic                 ovf_q;
	logic                 wrap_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS:0]   sum;
	logic                 mc_hi;

	// One multiplier bit per cycle, MSB first: acc = 2*acc + bit*mcand.
	// Any bit carried out of the word marks a true overflow.
	always_comb begin
		mc_hi = acc_q[WORD_BITS-1];
		sum = {1'b0, acc_q[WORD_BITS-2:0], 1'b0}
			+ (mplier_q[WORD_BITS-1] ? {1'b0, mcand_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(WORD_BITS);
				acc_q <= '0;
				mcand_q <= a;
				mplier_q <= b;
				ovf_q <= 1'b0;
				wrap_q <= ctl.wrap;
			end else if (busy_q) begin
				acc_q <= sum[WORD_BITS-1:0];
				mplier_q <= {mplier_q[WORD_BITS-2:0], 1'b0};
				ovf_q <= ovf_q | mc_hi | sum[WORD_BITS];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign p = acc_q;
	assign sts.done = done_q;
	assign sts.ovf = ovf_q & ~wrap_q;

endmodule

FILE: rtl/core/smia_div.sv
`timescale 1ns / 1ps
module smia_div import smia_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] num,
	input  logic [WORD_BITS-1:0] den,
	output logic                 done,
	output logic [WORD_BITS-1:0] quo,
	output logic [WORD_BITS-1:0] rem
);

	localparam int CW = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] q_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] d_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		trial = {r_q, q_q[WORD_BITS-1]};
		diff = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(WORD_BITS);
				q_q <= num;
				r_q <= '0;
				d_q <= den;
			end else if (busy_q) begin
				if (!diff[WORD_BITS]) begin
					r_q <= diff[WORD_BITS-1:0];
				end else begin
					r_q <= trial[WORD_BITS-1:0];
				end
				q_q <= {q_q[WORD_BITS-2:0], ~diff[WORD_BITS]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = q_q;
	assign rem = r_q;

endmodule

FILE: sim/sign_magnitude_integer_alu_tb.sv
`timescale 1ns / 1ps
module sign_magnitude_integer_alu_tb;
	import smia_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [1:0] K_SPARE = 2'd3;
	localparam logic [63:0] MAG_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint CYCLE_LIMIT = 15000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	out_word_t pending_results[$];
	int errors = 0;
	longint cycles = 0;
	bit idle_on = 1'b1;
	int hold_left = 0;
	int stall_left = 0;

	sign_magnitude_integer_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// True 64-bit overflow of an unsigned product.
	function automatic bit mul_ovf(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[127:64] != 64'd0;
	endfunction

	// Square-and-multiply power, stopping at the first overflowing step.
	function automatic logic [2:0] power_of(input logic [63:0] base_in,
			input logic [63:0] ex_in, input bit wrap, output logic [63:0] res);
		logic [63:0] acc;
		logic [63:0] b;
		logic [63:0] e;
		acc = 64'd1;
		b = base_in;
		e = ex_in;
		res = 64'd0;
		while (e != 64'd0) begin
			if (e[0]) begin
				if (!wrap && mul_ovf(acc, b))
					return ST_OVF;
				acc = acc * b;
			end
			e = e >> 1;
			if (e != 64'd0) begin
				if (!wrap && mul_ovf(b, b))
					return ST_OVF;
				b = b * b;
			end
		end
		res = acc;
		return ST_OK;
	endfunction

	// Computes the expected word for one operand pair.
	function automatic out_word_t alu_result(input in_word_t w);
		logic [63:0] xv;
		logic [63:0] yv;
		logic [63:0] mag;
		logic [1:0] xt;
		logic [1:0] yt;
		logic [1:0] kind;
		logic [2:0] st;
		bit based;
		bit xneg;
		bit yneg;
		out_word_t r;
		xv = w.x_mag;
		yv = w.y_mag;
		xt = (w.x_kind == K_SPARE) ? K_BASED : w.x_kind;
		yt = (w.y_kind == K_SPARE) ? K_BASED : w.y_kind;
		based = (xt == K_BASED) || (yt == K_BASED);
		xneg = (xt == K_NEG);
		yneg = (yt == K_NEG);
		mag = 64'd0;
		kind = K_POS;
		st = ST_OK;
		case (w.operation)
			OP_ADD: begin
				kind = xt;
				if (based) begin
					mag = yv + xv;
				end else if (xneg == yneg) begin
					if (xv > MAG_MAX - yv)
						st = ST_OVF;
					else
						mag = xv + yv;
				end else if (yv >= xv) begin
					mag = yv - xv;
					kind = (mag == 0 || xneg) ? K_POS : K_NEG;
				end else begin
					mag = xv - yv;
				end
			end
			OP_SUB: begin
				kind = xt;
				if (based) begin
					mag = yv - xv;
				end else if (xneg != yneg) begin
					if (xv > MAG_MAX - yv)
						st = ST_OVF;
					else
						mag = xv + yv;
					kind = yt;
				end else if (yv > xv) begin
					mag = yv - xv;
				end else begin
					mag = xv - yv;
					kind = (mag == 0 || xneg) ? K_POS : K_NEG;
				end
			end
			OP_MUL: begin
				if (based) begin
					mag = yv * xv;
					kind = xt;
				end else if (mul_ovf(xv, yv)) begin
					st = ST_OVF;
				end else begin
					mag = xv * yv;
					kind = (xneg == yneg) ? K_POS : K_NEG;
				end
			end
			OP_DIV: begin
				if (xv == 0) begin
					st = ST_DIVZERO;
				end else if (based) begin
					mag = yv / xv;
					kind = xt;
				end else if (yv % xv != 0) begin
					st = ST_INEXACT;
				end else begin
					mag = yv / xv;
					kind = (xneg == yneg) ? K_POS : K_NEG;
				end
			end
			OP_MOD: begin
				if (xv == 0) begin
					st = ST_DIVZERO;
				end else if (based) begin
					mag = yv % xv;
					kind = xt;
				end else begin
					mag = yv % xv;
					if (xneg)
						mag = yv - mag;
					kind = K_POS;
				end
			end
			OP_REM: begin
				if (xv == 0) begin
					st = ST_DIVZERO;
				end else begin
					mag = yv % xv;
					kind = xt;
				end
			end
			OP_POW: begin
				if (xv == 0 && yv == 0) begin
					st = ST_ZPZ;
				end else begin
					if (yneg)
						kind = xv[0] ? K_NEG : K_POS;
					else
						kind = yt;
					st = power_of(yv, xv, based, mag);
				end
			end
			default: ;
		endcase
		if (st != ST_OK) begin
			mag = 64'd0;
			kind = K_POS;
		end
		r.result_mag = mag;
		r.result_kind = kind;
		r.status = st;
		return r;
	endfunction

	function automatic in_word_t mk(input logic [2:0] op, input logic [63:0] xm,
			input logic [1:0] xk, input logic [63:0] ym, input logic [1:0] yk);
		in_word_t w;
		w.operation = op;
		w.x_mag = xm;
		w.x_kind = xk;
		w.y_mag = ym;
		w.y_kind = yk;
		return w;
	endfunction

	// Sends one word after a random gap and records its expected result.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = w;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(alu_result(w));
		@(negedge clk);
	endtask

	// The receiver: random stalls per word, plus long hold-offs on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	// Compares every taken result with the oldest expectation.
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			stall_left = idle_on ? $urandom_range(0, 11) : 0;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_data);
				errors++;
			end else begin
				exp_w = pending_results.pop_front();
				if (out_data.result_mag !== exp_w.result_mag) begin
					$display("%0t: result_mag expected %h actual %h", $time,
						exp_w.result_mag, out_data.result_mag);
					errors++;
				end
				if (out_data.result_kind !== exp_w.result_kind) begin
					$display("%0t: result_kind expected %0d actual %0d", $time,
						exp_w.result_kind, out_data.result_kind);
					errors++;
				end
				if (out_data.status !== exp_w.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_w.status, out_data.status);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_mag();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return 64'd1;
			2: return MAG_MAX;
			3: return 64'd1 << $urandom_range(0, 63);
			4: return (64'd1 << $urandom_range(1, 63)) - 64'd1;
			5: return 64'($urandom_range(0, 20));
			6: return {32'd0, v[31:0]};
			default: return v;
		endcase
	endfunction

	function automatic logic [1:0] rand_kind();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return K_POS;
			4, 5, 6: return K_NEG;
			7, 8: return K_BASED;
			default: return K_SPARE;
		endcase
	endfunction

	// Boundary cases: overflow, zero divisors, zero power zero, spare tags, an unused opcode.
	task automatic test_special_cases();
		send_word(mk(OP_ADD, MAG_MAX, K_POS, 64'd1, K_POS));
		send_word(mk(OP_ADD, MAG_MAX, K_NEG, MAG_MAX, K_NEG));
		send_word(mk(OP_SUB, MAG_MAX, K_NEG, 64'd1, K_POS));
		send_word(mk(OP_MUL, MAG_MAX, K_POS, 64'd2, K_NEG));
		send_word(mk(OP_MUL, 64'd0, K_NEG, 64'd5, K_POS));
		send_word(mk(OP_DIV, 64'd0, K_POS, 64'd7, K_POS));
		send_word(mk(OP_MOD, 64'd0, K_BASED, 64'd7, K_POS));
		send_word(mk(OP_REM, 64'd0, K_NEG, 64'd7, K_NEG));
		send_word(mk(OP_POW, 64'd0, K_POS, 64'd0, K_POS));
		send_word(mk(OP_POW, 64'd0, K_BASED, 64'd0, K_NEG));
		send_word(mk(OP_DIV, 64'd3, K_POS, 64'd7, K_POS));
		send_word(mk(OP_ADD, MAG_MAX, K_SPARE, 64'd3, K_POS));
		send_word(mk(OP_SUB, 64'd5, K_POS, 64'd2, K_SPARE));
		send_word(mk(OP_UNUSED, MAG_MAX, K_SPARE, MAG_MAX, K_SPARE));
		send_word(mk(OP_POW, 64'd64, K_POS, 64'd2, K_POS));
	endtask

	// One word of each operation, two for pow, with a mix of signs and kinds.
	task automatic test_each_operation();
		send_word(mk(OP_ADD, 64'd9, K_NEG, 64'd4, K_POS));
		send_word(mk(OP_SUB, 64'd4, K_NEG, 64'd4, K_NEG));
		send_word(mk(OP_MUL, 64'h1_0000_0000, K_NEG, 64'hFFFF_FFFF, K_NEG));
		send_word(mk(OP_DIV, 64'd6, K_NEG, 64'd42, K_POS));
		send_word(mk(OP_MOD, 64'd5, K_NEG, 64'd17, K_POS));
		send_word(mk(OP_REM, 64'd5, K_NEG, 64'd17, K_POS));
		send_word(mk(OP_POW, 64'd7, K_NEG, 64'd3, K_NEG));
		send_word(mk(OP_POW, MAG_MAX, K_BASED, 64'd3, K_POS));
	endtask

	// Random mix; exact quotients and small exponents keep the deep paths busy.
	task automatic test_random_mix(input int n);
		in_word_t w;
		for (int i = 0; i < n; i++) begin
			idle_on = !(i >= n / 3 && i < n / 3 + 60);
			w = mk(3'($urandom_range(0, 7)), rand_mag(), rand_kind(), rand_mag(),
				rand_kind());
			if (w.operation == OP_DIV && $urandom_range(0, 1) && w.x_mag != 0)
				w.y_mag = w.x_mag * 64'($urandom_range(0, 1000));
			if (w.operation == OP_POW && $urandom_range(0, 19) != 0)
				w.x_mag = 64'($urandom_range(0, 70));
			send_word(w);
		end
		idle_on = 1'b1;
	endtask

	// A long hold on the result side while words keep coming.
	task automatic test_backpressure();
		hold_left = 300;
		for (int i = 0; i < 12; i++)
			send_word(mk(OP_ADD, rand_mag(), rand_kind(), rand_mag(), rand_kind()));
	endtask

	// The sender stops until every result is back, then resumes.
	task automatic test_drain_pause();
		for (int i = 0; i < 10; i++)
			send_word(mk(3'($urandom_range(0, 6)), rand_mag(), rand_kind(), rand_mag(),
				K_POS));
		in_valid = 1'b0;
		wait_drained();
		for (int i = 0; i < 10; i++)
			send_word(mk(3'($urandom_range(0, 5)), rand_mag(), rand_kind(), rand_mag(),
				K_NEG));
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_cases();
		test_each_operation();
		test_backpressure();
		test_drain_pause();
		test_random_mix(500);
		in_valid = 1'b0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/smia_pkg.sv
rtl/core/smia_mul.sv
rtl/core/smia_div.sv
rtl/core/sign_magnitude_integer_alu.sv
sim/sign_magnitude_integer_alu_tb.sv
